>>> hdl/cssl_pkg.sv
package cssl_pkg;

    localparam int STAGES_DEF      = 9;
    localparam int SAMPLE_BITS_DEF = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int OVER_W     = 24;
    localparam int RECIP_W    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OVER_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNDER_RECIP  = 2'd2;

    localparam logic [OVER_W-1:0] OVER_BASE_RST = 24'd4194304;

    // Fixed-point formats
    localparam int OVER_FRAC  = 22;
    localparam int RECIP_FRAC = 12;
    localparam int STICK_W    = 24;
    localparam int PHI_FRAC   = 24;
    localparam int PHI_W      = 35;
    localparam int PHI_LO_W   = 18;

    localparam longint unsigned PHI_Q32 = 64'd6949403065;

    typedef struct packed {
        logic [OVER_W-1:0]  over_base;
        logic               under_enable;
        logic [RECIP_W-1:0] under_recip;
    } cssl_cfg_t;

    // phi^n in Q24, built from Fibonacci numbers: F(n)*phi + F(n-1)
    function automatic logic [PHI_W-1:0] phi_pow_q24(input int unsigned n);
        longint unsigned fprev;
        longint unsigned fcur;
        longint unsigned tmp;
        longint unsigned q32;
        int unsigned     nn;
        nn    = n & 32'd15;
        fprev = 64'd0;
        fcur  = 64'd1;
        for (int unsigned k = 1; k < 16; k++)
        begin
            if (k < nn)
            begin
                tmp   = fcur + fprev;
                fprev = fcur;
                fcur  = tmp;
            end
        end
        q32 = fcur * PHI_Q32 + (fprev << 32);
        if (nn == 0)
            return PHI_W'(64'd1 << PHI_FRAC);
        return PHI_W'((q32 + 64'd128) >> 8);
    endfunction

endpackage

>>> hdl/cssl_if.sv
interface cssl_in_if #(parameter int SAMPLE_BITS = cssl_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          end_in;

    modport source (output valid, output sample_in, output end_in, input ready);
    modport sink (input valid, input sample_in, input end_in, output ready);
endinterface

interface cssl_out_if #(parameter int SAMPLE_BITS = cssl_pkg::SAMPLE_BITS_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          end_out;

    modport source (output valid, output sample_out, output end_out, input ready);
    modport sink (input valid, input sample_out, input end_out, output ready);
endinterface

>>> hdl/cascaded_sticky_slew_limiter.sv
// Nine-stage (STAGES) sticky slew limiter for signed audio samples. Each sample walks
// a row of stage cells, first cell widest threshold; every cell keeps its own previous
// output and takes each sample in turn through difference and stick multiply, pull
// multiply, rounding and clamp, because its next sample needs the value it stores at
// the end of this one. All cells move in lockstep, advancing once per sample period
// unless the result is blocked; a sample passes from the input slot through every
// cell in turn to the output register. Stage history clears at reset with no sweep.
// Write registers only while no transaction is in flight; wr_index 3 is ignored.
module cascaded_sticky_slew_limiter #(
    parameter int STAGES      = cssl_pkg::STAGES_DEF,
    parameter int SAMPLE_BITS = cssl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cssl_in_if.sink                           feed,
    cssl_out_if.source                        result,
    input  logic                              wr_en,
    input  logic [cssl_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cssl_pkg::CFG_DATA_W-1:0]   wr_data
);
    import cssl_pkg::*;

    typedef enum logic [3:0] {
        PH_DIFF  = 4'b0001,
        PH_SCALE = 4'b0010,
        PH_PULL  = 4'b0100,
        PH_CLAMP = 4'b1000
    } phase_t;

    phase_t                        phase_reg;
    phase_t                        phase_next;
    cssl_cfg_t                     cfg_reg;
    logic                          slot_valid_reg;
    logic signed [SAMPLE_BITS-1:0] slot_sample_reg;
    logic                          slot_end_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_end_reg;

    logic                          advance;
    logic                          accept;
    logic                          valid_chain [STAGES+1];
    logic signed [SAMPLE_BITS-1:0] x_chain [STAGES+1];
    logic                          end_chain [STAGES+1];

    assign accept     = feed.valid && !slot_valid_reg;
    assign feed.ready = !slot_valid_reg;

    // Shift the whole row once per sample period, unless the result is blocked
    assign advance = (phase_reg == PH_CLAMP)
                     && (!valid_chain[STAGES] || !out_valid_reg || result.ready);

    always_comb
    begin
        case (phase_reg)
            PH_DIFF:  phase_next = PH_SCALE;
            PH_SCALE: phase_next = PH_PULL;
            PH_PULL:  phase_next = PH_CLAMP;
            PH_CLAMP: phase_next = advance ? PH_DIFF : PH_CLAMP;
            default:  phase_next = PH_DIFF;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_DIFF;
            slot_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cfg_reg        <= '{over_base: OVER_BASE_RST, under_enable: 1'b0,
                                under_recip: '0};
        end
        else
        begin
            phase_reg <= phase_next;
            if (accept)
                slot_valid_reg <= 1'b1;
            else if (advance)
                slot_valid_reg <= 1'b0;
            if (advance && valid_chain[STAGES])
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (wr_en)
            begin
                case (wr_index)
                    REG_OVER_BASE:    cfg_reg.over_base    <= wr_data[OVER_W-1:0];
                    REG_UNDER_ENABLE: cfg_reg.under_enable <= wr_data[0];
                    REG_UNDER_RECIP:  cfg_reg.under_recip  <= wr_data[RECIP_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_sample_reg <= feed.sample_in;
            slot_end_reg    <= feed.end_in;
        end
        if (advance && valid_chain[STAGES])
        begin
            out_sample_reg <= x_chain[STAGES];
            out_end_reg    <= end_chain[STAGES];
        end
    end

    assign valid_chain[0] = slot_valid_reg;
    assign x_chain[0]     = slot_sample_reg;
    assign end_chain[0]   = slot_end_reg;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        cssl_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .PHI_EXP     (STAGES - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cfg       (cfg_reg),
            .valid_in  (valid_chain[k]),
            .x_in      (x_chain[k]),
            .end_in    (end_chain[k]),
            .valid_out (valid_chain[k+1]),
            .x_out     (x_chain[k+1]),
            .end_out   (end_chain[k+1])
        );
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_sample_reg;
    assign result.end_out    = out_end_reg;

`ifndef SYNTHESIS
    a_advance_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> !advance ##1 !advance ##1 !advance)
        else $error("row advanced before a full sample period");

    a_slot_enters_row: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (valid_chain[1] == $past(slot_valid_reg)))
        else $error("first cell valid does not follow the input slot");

    a_last_cell_unloads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && valid_chain[STAGES]) |=> out_valid_reg)
        else $error("last cell result dropped");
`endif

endmodule

>>> hdl/cssl_cell.sv
module cssl_cell #(
    parameter int SAMPLE_BITS = cssl_pkg::SAMPLE_BITS_DEF,
    parameter int PHI_EXP     = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  cssl_pkg::cssl_cfg_t           cfg,
    input  logic                          valid_in,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic                          end_in,
    output logic                          valid_out,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic                          end_out
);
    import cssl_pkg::*;

    localparam int FRAC  = SAMPLE_BITS - 1;
    localparam int DW    = SAMPLE_BITS + 1;
    localparam int P1W   = SAMPLE_BITS + RECIP_W;
    localparam int SH1   = FRAC - RECIP_FRAC;
    localparam int P2W   = DW + STICK_W + 1;
    localparam int UW    = SAMPLE_BITS - 3;
    localparam int QPW   = UW + SAMPLE_BITS;
    localparam int LO_PW = OVER_W + PHI_LO_W;
    localparam int HI_PW = OVER_W + PHI_W - PHI_LO_W;
    localparam int TU_W  = OVER_W + PHI_W;
    localparam int T_SH  = PHI_FRAC + OVER_FRAC - FRAC;
    localparam int TW    = TU_W + 1 - T_SH;
    localparam int CW    = TW + 2;

    localparam longint unsigned DIV5_L = ((64'd1 << SAMPLE_BITS) + 64'd4) / 64'd5;
    localparam logic [SAMPLE_BITS-1:0] DIV5_M  = SAMPLE_BITS'(DIV5_L);
    localparam logic [PHI_W-1:0]       PHI_POW = phi_pow_q24(PHI_EXP);
    localparam logic [TU_W-1:0]        T_HALF  = TU_W'(1) << (T_SH - 1);
    localparam logic [P2W-1:0]         P_HALF  = P2W'(1) << (STICK_W - 1);

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] p_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          end_reg;

    logic signed [DW-1:0]          d_reg;
    logic [P1W-1:0]                prod1_reg;
    logic [QPW-1:0]                qprod_reg;
    logic signed [P2W-1:0]         prod2_reg;
    logic                          stick_reg;
    logic signed [SAMPLE_BITS-1:0] q_reg;
    logic signed [SAMPLE_BITS-1:0] xs_reg;
    logic [LO_PW-1:0]              lo_prod_reg;
    logic [HI_PW-1:0]              hi_prod_reg;
    logic [TW-1:0]                 thr_reg;

    logic signed [DW-1:0]          d_next;
    logic [SAMPLE_BITS-1:0]        ad;
    logic [P1W-1:0]                prod1_next;
    logic [SAMPLE_BITS-1:0]        pm;
    logic [SAMPLE_BITS-1:0]        m19;
    logic [UW-1:0]                 u8;
    logic [QPW-1:0]                qprod_next;
    logic [STICK_W-1:0]            sfac;
    logic signed [P2W-1:0]         prod2_next;
    logic                          stick_next;
    logic [SAMPLE_BITS-1:0]        q_mag;
    logic signed [SAMPLE_BITS-1:0] q_next;
    logic                          p2_neg;
    logic [P2W-1:0]                p2_mag;
    logic [P2W-1:0]                p2_rnd;
    logic [DW-1:0]                 pull_mag;
    logic signed [DW-1:0]          pull;
    logic signed [SAMPLE_BITS-1:0] xs_next;
    logic [TU_W-1:0]               t_sum;
    logic [TW-1:0]                 thr_next;
    logic signed [CW-1:0]          thr_s;
    logic signed [CW-1:0]          dx;
    logic signed [CW-1:0]          clamp;

    // Pull toward the previous output: difference and stick factor product
    always_comb
    begin
        d_next     = DW'(x_reg) - DW'(p_reg);
        ad         = d_next[DW-1] ? SAMPLE_BITS'(-d_next) : SAMPLE_BITS'(d_next);
        prod1_next = P1W'(ad) * P1W'(cfg.under_recip);
    end

    // 0.975 * |p| = m - floor((m + 19) / 40); the divide by 5 is a reciprocal multiply
    always_comb
    begin
        pm         = p_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-p_reg) : SAMPLE_BITS'(p_reg);
        m19        = pm + SAMPLE_BITS'(19);
        u8         = m19[SAMPLE_BITS-1:3];
        qprod_next = QPW'(u8) * QPW'(DIV5_M);
        q_mag      = pm - SAMPLE_BITS'(qprod_reg[QPW-1:SAMPLE_BITS]);
        q_next     = p_reg[SAMPLE_BITS-1] ? -$signed(q_mag) : $signed(q_mag);
    end

    always_comb
    begin
        sfac       = prod1_reg[SH1+STICK_W-1:SH1];
        stick_next = cfg.under_enable && (prod1_reg[P1W-1:SH1+STICK_W] == '0);
        prod2_next = P2W'(d_reg) * P2W'($signed({1'b0, sfac}));
    end

    // Round the pull half away from zero
    always_comb
    begin
        p2_neg   = prod2_reg[P2W-1];
        p2_mag   = p2_neg ? P2W'(-prod2_reg) : P2W'(prod2_reg);
        p2_rnd   = (p2_mag + P_HALF) >> STICK_W;
        pull_mag = p2_rnd[DW-1:0];
        pull     = p2_neg ? -$signed(pull_mag) : $signed(pull_mag);
        xs_next  = stick_reg ? SAMPLE_BITS'(DW'(p_reg) + pull) : x_reg;
    end

    // Stage threshold tracks over_base; product split into a low and a high part
    always_comb
    begin
        t_sum    = TU_W'(lo_prod_reg) + (TU_W'(hi_prod_reg) << PHI_LO_W) + T_HALF;
        thr_next = TW'(t_sum >> T_SH);
    end

    always_comb
    begin
        thr_s = CW'($signed({1'b0, thr_reg}));
        dx    = CW'(xs_reg) - CW'(q_reg);
        if (dx > thr_s)
            clamp = CW'(q_reg) + thr_s;
        else if (-dx > thr_s)
            clamp = CW'(q_reg) - thr_s;
        else
            clamp = CW'(xs_reg);
    end

    assign x_out     = SAMPLE_BITS'(clamp);
    assign valid_out = valid_reg;
    assign end_out   = end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            p_reg     <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
            if (valid_reg)
                p_reg <= x_out;
        end
    end

    // Datapath runs every cycle; inputs hold still between advances
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg   <= x_in;
            end_reg <= end_in;
        end
        d_reg       <= d_next;
        prod1_reg   <= prod1_next;
        qprod_reg   <= qprod_next;
        prod2_reg   <= prod2_next;
        stick_reg   <= stick_next;
        q_reg       <= q_next;
        xs_reg      <= xs_next;
        lo_prod_reg <= LO_PW'(cfg.over_base) * LO_PW'(PHI_POW[PHI_LO_W-1:0]);
        hi_prod_reg <= HI_PW'(cfg.over_base) * HI_PW'(PHI_POW[PHI_W-1:PHI_LO_W]);
        thr_reg     <= thr_next;
    end

endmodule

>>> bench/cascaded_sticky_slew_limiter_tb.sv
`timescale 1ns / 100ps

module cascaded_sticky_slew_limiter_tb;
    import cssl_pkg::*;

    localparam int NST             = STAGES_DEF;
    localparam int SW              = SAMPLE_BITS_DEF;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int HOLD_AFTER      = 450;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_CAP      = 40;
    localparam int SAMPLE_MAX      = 8388607;
    localparam int SAMPLE_MIN      = -8388608;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  tail;
        logic                  typed;
        logic [SW-1:0]         want;
    } plan_row_t;

    typedef struct {
        logic signed [SW-1:0] smp;
        logic                 tail;
    } audio_res_t;

    localparam int N_PLAN = 29;
    localparam plan_row_t PLAN [N_PLAN] = '{
        '{ROW_SAMPLE, '0,               24'h000000, 1'b0, 1'b1, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF},
        '{ROW_SAMPLE, '0,               24'h800000, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h800000, 1'b1, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h000001, 1'b0, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_OVER_BASE,    24'h000000, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h800000, 1'b1, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_OVER_BASE,    24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
        // thresholds of two or more: the sample passes untouched
        '{ROW_SAMPLE, '0,               24'h003039, 1'b0, 1'b1, 24'h003039},
        '{ROW_SAMPLE, '0,               24'h800000, 1'b0, 1'b1, 24'h800000},
        // zero reciprocal: every stage sticks to its previous output
        '{ROW_WRITE,  REG_UNDER_ENABLE, 24'h000001, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h7FFFFF, 1'b0, 1'b1, 24'h800000},
        '{ROW_SAMPLE, '0,               24'h000000, 1'b1, 1'b1, 24'h800000},
        '{ROW_WRITE,  REG_UNDER_RECIP,  24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h800001, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_UNDER_RECIP,  24'h001000, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h3D0900, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h3D0964, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'hFFFFFE, 1'b0, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_SPARE,        24'hFFFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h000007, 1'b1, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_OVER_BASE,    24'h004E20, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h7FFFFF, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h800000, 1'b0, 1'b0, 24'h000000},
        '{ROW_WRITE,  REG_UNDER_ENABLE, 24'h000000, 1'b0, 1'b0, 24'h000000},
        '{ROW_SAMPLE, '0,               24'h000064, 1'b1, 1'b0, 24'h000000}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    cssl_in_if  #(.SAMPLE_BITS(SW)) feed_if ();
    cssl_out_if #(.SAMPLE_BITS(SW)) result_if ();

    cascaded_sticky_slew_limiter #(
        .STAGES      (NST),
        .SAMPLE_BITS (SW)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed_if),
        .result   (result_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // limiter state as the block should hold it
    logic [OVER_W-1:0]    over_cfg;
    logic                 stick_cfg;
    logic [RECIP_W-1:0]   recip_cfg;
    logic signed [SW-1:0] stage_hist [NST];
    longint               limit_q23 [NST];

    audio_res_t pending_q [$];
    int         err_count      = 0;
    int         accepted_total = 0;
    bit         calm           = 1'b0;
    bit         hold_sink;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // per-stage threshold: over_base * phi^(NST-1-k), phi^n = F(n)*phi + F(n-1)
    function automatic void refresh_limits();
        longint fa;
        longint fb;
        longint nxt;
        longint phi;
        for (int k = 0; k < NST; k++)
        begin
            fa = 0;
            fb = 1;
            for (int i = 1; i < NST - 1 - k; i++)
            begin
                nxt = fa + fb;
                fa  = fb;
                fb  = nxt;
            end
            if (k == NST - 1)
                phi = longint'(1) << PHI_FRAC;
            else
                phi = (fb * longint'(PHI_Q32) + (fa << 32) + 128) >>> 8;
            limit_q23[k] = (longint'(over_cfg) * phi + (longint'(1) << (OVER_FRAC + PHI_FRAC - SW)))
                           >>> (OVER_FRAC + PHI_FRAC - SW + 1);
        end
    endfunction

    function automatic logic signed [SW-1:0] slew_chain_predict(input logic signed [SW-1:0] smp);
        longint x;
        longint p;
        longint d;
        longint mag;
        longint s24;
        longint q;
        longint t;
        x = longint'(smp);
        for (int k = 0; k < NST; k++)
        begin
            p = longint'(stage_hist[k]);
            if (stick_cfg)
            begin
                d   = x - p;
                mag = (d < 0) ? -d : d;
                s24 = (mag * longint'(recip_cfg)) >>> (SW - 1 - RECIP_FRAC);
                if (s24 < (longint'(1) << STICK_W))
                begin
                    // pull toward p, round half away from zero
                    mag = d * s24;
                    mag = (((mag < 0) ? -mag : mag) + (longint'(1) << (STICK_W - 1))) >>> STICK_W;
                    x   = (d < 0) ? p - mag : p + mag;
                end
            end
            mag = (p < 0) ? -p : p;
            mag = (mag * 39 + 20) / 40;
            q   = (p < 0) ? -mag : mag;
            t   = limit_q23[k];
            if (x - q > t)
                x = q + t;
            else if (q - x > t)
                x = q - t;
            stage_hist[k] = x[SW-1:0];
        end
        return x[SW-1:0];
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_sample(input logic [SW-1:0] smp, input logic tail, input logic typed,
                               input logic [SW-1:0] want);
        audio_res_t res;
        int         gap;
        feed_if.valid     <= 1'b1;
        feed_if.sample_in <= smp;
        feed_if.end_in    <= tail;
        do
            @(posedge clk);
        while (!feed_if.ready);
        res.smp = slew_chain_predict(smp);
        if (typed)
            res.smp = want;
        res.tail = tail;
        pending_q.push_back(res);
        accepted_total++;
        gap = idle_len();
        if (gap > 0)
        begin
            feed_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        if (feed_if.valid)
            feed_if.valid <= 1'b0;
        // hold the write until no transaction is in flight
        while (pending_q.size() != 0)
            @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_OVER_BASE:
            begin
                over_cfg = val[OVER_W-1:0];
                refresh_limits();
            end
            REG_UNDER_ENABLE: stick_cfg = val[0];
            REG_UNDER_RECIP:  recip_cfg = val[RECIP_W-1:0];
            default: ;
        endcase
    endtask

    initial
    begin : stimulus
        int                    walk;
        int                    span;
        int                    pick;
        logic [CFG_DATA_W-1:0] cfg_val;
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = '0;
        wr_data           = '0;
        feed_if.valid     = 1'b0;
        feed_if.sample_in = '0;
        feed_if.end_in    = 1'b0;
        over_cfg          = OVER_BASE_RST;
        stick_cfg         = 1'b0;
        recip_cfg         = '0;
        for (int k = 0; k < NST; k++)
            stage_hist[k] = '0;
        refresh_limits();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PLAN; i++)
        begin
            if (PLAN[i].kind == ROW_WRITE)
                write_reg(PLAN[i].idx, PLAN[i].val);
            else
                push_sample(PLAN[i].val, PLAN[i].tail, PLAN[i].typed, PLAN[i].want);
        end

        walk = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            calm = (ph % 3 == 1);
            case ($urandom_range(0, 5))
                0:       cfg_val = '0;
                1:       cfg_val = '1;
                2:       cfg_val = OVER_BASE_RST;
                5:       cfg_val = CFG_DATA_W'($urandom);
                default: cfg_val = CFG_DATA_W'($urandom_range(0, 1 << 18));
            endcase
            write_reg(REG_OVER_BASE, cfg_val);
            write_reg(REG_UNDER_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 4))
                0:       cfg_val = '0;
                1:       cfg_val = '1;
                2:       cfg_val = CFG_DATA_W'($urandom_range(0, 8192));
                3:       cfg_val = CFG_DATA_W'($urandom_range(0, 1 << 20));
                default: cfg_val = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_UNDER_RECIP, cfg_val);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    // audio-like walk with steps from tiny to large
                    span = 1 << (2 + 4 * $urandom_range(0, 4));
                    walk = walk + int'($urandom_range(0, 2 * span)) - span;
                    if (walk > SAMPLE_MAX)
                        walk = SAMPLE_MAX;
                    else if (walk < SAMPLE_MIN)
                        walk = SAMPLE_MIN;
                end
                else if (pick < 8)
                    walk = int'($urandom) >>> 8;
                else if (pick == 8)
                    walk = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
                else
                    walk = 0;
                push_sample(walk[SW-1:0], $urandom_range(0, 15) == 0, 1'b0, '0);
            end
        end

        if (feed_if.valid)
            feed_if.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : drain_results
        audio_res_t want;
        int         stall_left;
        result_if.ready = 1'b0;
        stall_left      = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_CAP)
                        $display("%0t: transaction with nothing pending: sample_out %0d end_out %0b",
                                 $time, result_if.sample_out, result_if.end_out);
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (result_if.sample_out !== want.smp)
                    begin
                        err_count++;
                        if (err_count <= REPORT_CAP)
                            $display("%0t: sample_out expected %0d actual %0d",
                                     $time, want.smp, result_if.sample_out);
                    end
                    if (result_if.end_out !== want.tail)
                    begin
                        err_count++;
                        if (err_count <= REPORT_CAP)
                            $display("%0t: end_out expected %0b actual %0b",
                                     $time, want.tail, result_if.end_out);
                    end
                end
            end
            if (hold_sink)
                result_if.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = idle_len();
                result_if.ready <= (stall_left == 0);
            end
        end
    end

    // block the output long enough for the chain to fill and stall its input
    initial
    begin : output_hold
        int held;
        hold_sink = 1'b0;
        wait (accepted_total >= HOLD_AFTER);
        @(posedge clk);
        hold_sink <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++)
            @(posedge clk);
        hold_sink <= 1'b0;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
